// ===== hw/rtl/dscg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscg_pkg
// Shared types and constants of the drive state controlword generator.
// ----------------------------------------------------------------------------
package dscg_pkg;

  typedef enum logic [3:0] {
    StNotReady      = 4'd0,
    StSwOnDisabled  = 4'd1,
    StReady         = 4'd2,
    StSwitchedOn    = 4'd3,
    StOpEnabled     = 4'd4,
    StQuickStop     = 4'd5,
    StFaultReaction = 4'd6,
    StFault         = 4'd7,
    StUnknown       = 4'd8
  } drive_state_e;

  typedef enum logic [1:0] {
    TgtDisabled = 2'd0,
    TgtEnabled  = 2'd1,
    TgtQuickStop = 2'd2,
    TgtSpare    = 2'd3
  } target_mode_e;

  localparam logic [15:0] CwOff      = 16'h0000;
  localparam logic [15:0] CwQstop    = 16'h0002;
  localparam logic [15:0] CwShutdown = 16'h0006;
  localparam logic [15:0] CwSwitchOn = 16'h0007;
  localparam logic [15:0] CwEnable   = 16'h000F;
  localparam logic [15:0] CwFreset   = 16'h0080;

  localparam logic [15:0] SwMask     = 16'h006F;
  localparam logic [15:0] SwMaskLow  = 16'h004F;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [CfgIdxW-1:0] CfgMaxRetries = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStuckThr   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPulseLen   = 2'd2;

  localparam logic [7:0]  MaxRetriesRst = 8'd5;
  localparam logic [15:0] StuckThrRst   = 16'd2000;
  localparam logic [9:0]  PulseLenRst   = 10'd50;

  typedef struct packed {
    logic [7:0]  max_init_retries;
    logic [15:0] stuck_threshold;
    logic [9:0]  reset_pulse_length;
  } cfg_t;

  typedef struct packed {
    logic [15:0] status_word;
    logic [1:0]  target_mode;
    logic        reset_request;
  } in_item_t;

  typedef struct packed {
    logic [15:0] control_word;
    logic [3:0]  drive_state;
    logic        reset_active;
  } out_item_t;

endpackage

// ===== hw/rtl/dscg_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscg_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dscg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dscg_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscg_decode
// Statusword to drive state decoder.
// ----------------------------------------------------------------------------
module dscg_decode (
  input  logic [15:0]           status_word_i,
  output dscg_pkg::drive_state_e drive_state_o
);
  import dscg_pkg::*;

  logic [15:0] m;
  logic [15:0] ml;

  always_comb begin
    m  = status_word_i & SwMask;
    ml = m & SwMaskLow;
    if (ml == 16'h0000) begin
      drive_state_o = StNotReady;
    end else if (ml == 16'h0040) begin
      drive_state_o = StSwOnDisabled;
    end else if (m == 16'h0021) begin
      drive_state_o = StReady;
    end else if (m == 16'h0023) begin
      drive_state_o = StSwitchedOn;
    end else if (m == 16'h0027) begin
      drive_state_o = StOpEnabled;
    end else if (m == 16'h0007) begin
      drive_state_o = StQuickStop;
    end else if (ml == 16'h000F) begin
      drive_state_o = StFaultReaction;
    end else if (ml == 16'h0008) begin
      drive_state_o = StFault;
    end else begin
      drive_state_o = StUnknown;
    end
  end

endmodule

// ===== hw/rtl/dscg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscg_ctrl
// Controlword selection, fault reset pulse timer and stuck/retry counters.
// ----------------------------------------------------------------------------
module dscg_ctrl #(
  parameter int unsigned StuckW = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dscg_pkg::cfg_t         cfg_i,
  input  logic                   step_i,
  input  dscg_pkg::drive_state_e state_i,
  input  logic [1:0]             target_mode_i,
  input  logic                   reset_request_i,
  output logic [15:0]            control_word_o,
  output logic                   reset_active_o
);
  import dscg_pkg::*;

  localparam int unsigned CmpW = (StuckW > 16) ? StuckW : 16;

  logic              pend_q, pend_d;
  logic [9:0]        pcnt_q, pcnt_d;
  logic [StuckW-1:0] stuck_q, stuck_d;
  logic [7:0]        retry_q, retry_d;

  logic              en, qs, pend0;
  logic [9:0]        pcnt0;
  logic [StuckW-1:0] stuck_inc;

  always_comb begin
    en = (target_mode_i == TgtEnabled);
    qs = (target_mode_i == TgtQuickStop);
    pend0 = pend_q | reset_request_i;
    pcnt0 = (reset_request_i && !pend_q) ? 10'd0 : pcnt_q;
    stuck_inc = (stuck_q != {StuckW{1'b1}}) ? stuck_q + StuckW'(1) : stuck_q;

    pend_d  = pend0;
    pcnt_d  = pcnt0;
    stuck_d = stuck_q;
    retry_d = retry_q;
    control_word_o = CwOff;
    reset_active_o = 1'b0;

    if (pend0) begin
      if (pcnt0 >= cfg_i.reset_pulse_length) begin
        pend_d = 1'b0;
        pcnt_d = 10'd0;
      end else begin
        pcnt_d = pcnt0 + 10'd1;
      end
      control_word_o = CwFreset;
      reset_active_o = 1'b1;
    end else begin
      case (state_i)
        StSwOnDisabled: begin
          stuck_d = '0;
          retry_d = 8'd0;
          control_word_o = en ? CwShutdown : CwOff;
        end
        StReady: begin
          control_word_o = en ? CwSwitchOn : (qs ? CwShutdown : CwOff);
        end
        StSwitchedOn: begin
          control_word_o = en ? CwEnable : (qs ? CwSwitchOn : CwOff);
        end
        StOpEnabled: begin
          control_word_o = en ? CwEnable : (qs ? CwQstop : CwSwitchOn);
        end
        StQuickStop: begin
          control_word_o = en ? CwEnable : CwOff;
        end
        StFaultReaction: begin
          control_word_o = CwOff;
        end
        StFault: begin
          if (en) begin
            pend_d = 1'b1;
            pcnt_d = 10'd0;
          end
        end
        default: begin
          if ((CmpW'(stuck_inc) > CmpW'(cfg_i.stuck_threshold)) &&
              (retry_q < cfg_i.max_init_retries)) begin
            retry_d = retry_q + 8'd1;
            stuck_d = '0;
          end else begin
            stuck_d = stuck_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      pcnt_q  <= 10'd0;
      stuck_q <= '0;
      retry_q <= 8'd0;
    end else if (step_i) begin
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      stuck_q <= stuck_d;
      retry_q <= retry_d;
    end
  end

endmodule

// ===== hw/rtl/drive_state_controlword_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_state_controlword_generator_core
// CiA 402 style drive state decoder and controlword generator.
//
// Usage: each input beat on in_i carries the drive statusword, the target
// mode and a fault reset request; each one yields exactly one output beat
// on out_o with the controlword, the decoded drive state and the reset
// pulse flag. Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while the block is idle: 0 max init retries, 1 stuck threshold,
// 2 reset pulse length.
// Flow: a beat accepted on in_i is registered in the input register, then
// decoded and registered in the output register that drives out_o.
// Throughput: one beat per cycle while out_o is taken; the pulse timer and
// stuck/retry counters update as a beat moves to the output register.
// Reset: rst_ni clears both pipeline valids, the pulse timer and counters,
// and loads the register defaults 5, 2000 and 50.
// Stall: when out_o is not taken, the output register holds its beat and
// the input register takes one more beat only if it is empty; in_i.ready then drops.
// ----------------------------------------------------------------------------
module drive_state_controlword_generator_core #(
  parameter int unsigned STUCK_COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  dscg_stream_if.sink                            in_i,
  dscg_stream_if.source                          out_o,
  input  logic                                   cfg_we_i,
  input  logic [dscg_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [dscg_pkg::CfgDataW-1:0]          cfg_wdata_i
);
  import dscg_pkg::*;

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic         advance;
  drive_state_e state;
  logic [1:0]   tgt;
  logic [15:0]  cw;
  logic         active;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_item_q;
  assign tgt = (in_item_q.target_mode == TgtSpare) ? TgtDisabled : in_item_q.target_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_init_retries   <= MaxRetriesRst;
      cfg_q.stuck_threshold    <= StuckThrRst;
      cfg_q.reset_pulse_length <= PulseLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxRetries: cfg_q.max_init_retries   <= cfg_wdata_i[7:0];
        CfgStuckThr:   cfg_q.stuck_threshold    <= cfg_wdata_i[15:0];
        CfgPulseLen:   cfg_q.reset_pulse_length <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  dscg_decode u_decode (
    .status_word_i (in_item_q.status_word),
    .drive_state_o (state)
  );

  dscg_ctrl #(
    .StuckW (STUCK_COUNT_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .step_i          (advance),
    .state_i         (state),
    .target_mode_i   (tgt),
    .reset_request_i (in_item_q.reset_request),
    .control_word_o  (cw),
    .reset_active_o  (active)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
    if (advance) begin
      out_item_q.control_word <= cw;
      out_item_q.drive_state  <= state;
      out_item_q.reset_active <= active;
    end
  end

endmodule

// ===== hw/rtl/dscg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dscg_checker
// Port-level checks of the controlword generator, bound to the top level.
// ----------------------------------------------------------------------------
module dscg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] control_word_i,
  input logic [3:0]  drive_state_i,
  input logic        reset_active_i
);
  import dscg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(control_word_i))
    else $error("output beat dropped or changed while stalled");

  a_pulse_cw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reset_active_i |-> control_word_i == CwFreset)
    else $error("reset pulse beat without fault reset controlword");

  a_cw_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !reset_active_i |->
      control_word_i == CwOff || control_word_i == CwQstop ||
      control_word_i == CwShutdown || control_word_i == CwSwitchOn ||
      control_word_i == CwEnable)
    else $error("unexpected controlword outside reset pulse");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> drive_state_i <= 4'd8)
    else $error("drive state out of range");

  a_fault_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !reset_active_i &&
      (drive_state_i == StFault || drive_state_i == StFaultReaction) |->
      control_word_i == CwOff)
    else $error("fault state must not command the drive");

endmodule

bind drive_state_controlword_generator_core dscg_checker u_dscg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .control_word_i (out_o.payload.control_word),
  .drive_state_i  (out_o.payload.drive_state),
  .reset_active_i (out_o.payload.reset_active)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the drive state controlword generator core.
// Sends statusword beats through the valid/ready input and predicts every
// output beat with a bench-side model of the state decoder, the fault reset
// pulse timer and the stuck/retry counters. Output beats are compared field
// by field in order. Directed decode and fault reset sequences come first.
// Random drive sequences follow over several register settings, including
// the extremes, under changing backpressure and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import dscg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  dscg_stream_if #(.payload_t(in_item_t))  in_if ();
  dscg_stream_if #(.payload_t(out_item_t)) out_if ();

  drive_state_controlword_generator_core #(.STUCK_COUNT_WIDTH(16)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  cfg_t        cfg_model;
  logic        fr_pending;
  logic [9:0]  fr_count;
  logic [15:0] stuck_cnt;
  logic [7:0]  retry_cnt;

  out_item_t   expected_beats[$];

  int          errors = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          settings_used = 0;
  int unsigned cycle_cnt = 0;
  int          snd_idle_pct = 9;
  int          rcv_idle_pct = 46;
  int          stall_seq = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic drive_state_e decode_state(logic [15:0] sw);
    logic [15:0] m;
    logic [15:0] lo;
    m  = sw & SwMask;
    lo = m & SwMaskLow;
    if (lo == 16'h0000) return StNotReady;
    if (lo == 16'h0040) return StSwOnDisabled;
    if (m == 16'h0021) return StReady;
    if (m == 16'h0023) return StSwitchedOn;
    if (m == 16'h0027) return StOpEnabled;
    if (m == 16'h0007) return StQuickStop;
    if (lo == 16'h000F) return StFaultReaction;
    if (lo == 16'h0008) return StFault;
    return StUnknown;
  endfunction

  function automatic out_item_t predict_beat(in_item_t it);
    drive_state_e st;
    target_mode_e tgt;
    logic         en;
    logic         qs;
    out_item_t    r;
    st  = decode_state(it.status_word);
    tgt = target_mode_e'(it.target_mode);
    if (tgt == TgtSpare) tgt = TgtDisabled;
    en = (tgt == TgtEnabled);
    qs = (tgt == TgtQuickStop);
    r.control_word = CwOff;
    r.drive_state  = st;
    r.reset_active = 1'b0;
    if (it.reset_request && !fr_pending) begin
      fr_pending = 1'b1;
      fr_count   = '0;
    end
    if (fr_pending) begin
      if (fr_count >= cfg_model.reset_pulse_length) begin
        fr_pending = 1'b0;
        fr_count   = '0;
      end else begin
        fr_count = fr_count + 10'd1;
      end
      r.control_word = CwFreset;
      r.reset_active = 1'b1;
    end else begin
      case (st)
        StSwOnDisabled: begin
          stuck_cnt      = '0;
          retry_cnt      = '0;
          r.control_word = en ? CwShutdown : CwOff;
        end
        StReady:         r.control_word = en ? CwSwitchOn : (qs ? CwShutdown : CwOff);
        StSwitchedOn:    r.control_word = en ? CwEnable : (qs ? CwSwitchOn : CwOff);
        StOpEnabled:     r.control_word = en ? CwEnable : (qs ? CwQstop : CwSwitchOn);
        StQuickStop:     r.control_word = en ? CwEnable : CwOff;
        StFaultReaction: r.control_word = CwOff;
        StFault: begin
          if (en) begin
            fr_pending = 1'b1;
            fr_count   = '0;
          end
        end
        default: begin
          if (stuck_cnt != 16'hFFFF) stuck_cnt = stuck_cnt + 16'd1;
          if (stuck_cnt > cfg_model.stuck_threshold &&
              retry_cnt < cfg_model.max_init_retries) begin
            retry_cnt = retry_cnt + 8'd1;
            stuck_cnt = '0;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic in_item_t beat_of(logic [15:0] sw, target_mode_e tgt, logic req);
    in_item_t it;
    it.status_word   = sw;
    it.target_mode   = tgt;
    it.reset_request = req;
    return it;
  endfunction

  function automatic logic [15:0] status_for(drive_state_e st);
    logic [15:0] sw;
    logic [15:0] free5;
    sw    = 16'($urandom) & ~SwMask;
    free5 = 16'($urandom) & 16'h0020;
    case (st)
      StNotReady:      sw = sw | free5;
      StSwOnDisabled:  sw = sw | free5 | 16'h0040;
      StReady:         sw = sw | 16'h0021;
      StSwitchedOn:    sw = sw | 16'h0023;
      StOpEnabled:     sw = sw | 16'h0027;
      StQuickStop:     sw = sw | 16'h0007;
      StFaultReaction: sw = sw | free5 | 16'h000F;
      StFault:         sw = sw | free5 | 16'h0008;
      default: begin
        sw = 16'($urandom);
        while (decode_state(sw) != StUnknown) sw = 16'($urandom);
      end
    endcase
    return sw;
  endfunction

  // receiver: random ready, or a long hold when a stall is requested
  initial begin
    int stall_seen;
    stall_seen   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_seen != stall_seq) begin
        stall_seen = stall_seq;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_out
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      end else begin
        want = expected_beats.pop_front();
        beats_checked++;
        if (got.control_word !== want.control_word) begin
          errors++;
          $display("%0t: control_word expected %h actual %h", $time,
                   want.control_word, got.control_word);
        end
        if (got.drive_state !== want.drive_state) begin
          errors++;
          $display("%0t: drive_state expected %0d actual %0d", $time,
                   want.drive_state, got.drive_state);
        end
        if (got.reset_active !== want.reset_active) begin
          errors++;
          $display("%0t: reset_active expected %b actual %b", $time,
                   want.reset_active, got.reset_active);
        end
      end
    end
  end

  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    expected_beats.push_back(predict_beat(it));
    beats_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves the write enable high; end_writes drops it
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgMaxRetries: cfg_model.max_init_retries   = data[7:0];
      CfgStuckThr:   cfg_model.stuck_threshold    = data[15:0];
      CfgPulseLen:   cfg_model.reset_pulse_length = data[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic apply_config(logic [15:0] retries, logic [15:0] thr, logic [15:0] plen);
    write_reg(CfgMaxRetries, retries);
    write_reg(CfgStuckThr, thr);
    write_reg(CfgPulseLen, plen);
    end_writes();
  endtask

  task automatic set_pace(int snd, int rcv);
    snd_idle_pct <= snd;
    rcv_idle_pct <= rcv;
  endtask

  // runs of one drive state, biased toward the power-up walk, plus noise
  task automatic run_drive(int n, int req_pct);
    drive_state_e run_state;
    target_mode_e run_tgt;
    target_mode_e tgt;
    int           run_left;
    int           i;
    logic         noisy;
    logic [15:0]  sw;
    run_left  = 0;
    run_state = StNotReady;
    run_tgt   = TgtEnabled;
    noisy     = 1'b0;
    for (i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(12, 1);
        if ($urandom_range(1) == 1 && run_state < StOpEnabled)
          run_state = drive_state_e'(run_state + 1);
        else
          run_state = drive_state_e'($urandom_range(8));
        run_tgt = target_mode_e'($urandom_range(3));
        noisy   = ($urandom_range(99) < 15);
      end
      run_left--;
      sw  = noisy ? 16'($urandom) : status_for(run_state);
      tgt = ($urandom_range(99) < 80) ? run_tgt : target_mode_e'($urandom_range(3));
      send_beat(beat_of(sw, tgt, $urandom_range(99) < req_pct));
    end
  endtask

  task automatic test_state_decode();
    apply_config(16'(MaxRetriesRst), StuckThrRst, 16'd0);
    send_beat(beat_of(16'h0000, TgtEnabled, 1'b0));
    send_beat(beat_of(16'hFF90, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0040, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0040, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0021, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0021, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0021, TgtQuickStop, 1'b0));
    send_beat(beat_of(16'h0023, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0023, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0023, TgtQuickStop, 1'b0));
    send_beat(beat_of(16'h0027, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0027, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0027, TgtQuickStop, 1'b0));
    send_beat(beat_of(16'h0007, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0007, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h000F, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtDisabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0021, TgtSpare, 1'b0));
    send_beat(beat_of(16'h0001, TgtEnabled, 1'b0));
    send_beat(beat_of(16'hFFFF, TgtSpare, 1'b1));
    drain();
  endtask

  task automatic test_fault_reset();
    apply_config(16'(MaxRetriesRst), StuckThrRst, 16'd2);
    send_beat(beat_of(16'h0021, TgtEnabled, 1'b1));
    send_beat(beat_of(16'h0027, TgtEnabled, 1'b1));
    send_beat(beat_of(16'h0027, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0027, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtQuickStop, 1'b0));
    send_beat(beat_of(16'h0028, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0008, TgtEnabled, 1'b0));
    send_beat(beat_of(16'h0040, TgtSpare, 1'b1));
    drain();
  endtask

  task automatic test_random_drive(logic [15:0] retries, logic [15:0] thr,
                                   logic [15:0] plen, int n);
    apply_config(retries, thr, plen);
    run_drive(n, 4);
    drain();
  endtask

  task automatic test_backpressure();
    set_pace(0, 0);
    stall_seq <= stall_seq + 1;
    run_drive(40, 4);
    drain();
  endtask

  task automatic test_register_masking();
    write_reg(CfgMaxRetries, 16'hAB01);
    write_reg(CfgStuckThr, 16'd7);
    write_reg(CfgPulseLen, 16'hFC09);
    write_reg(CfgIdxUnused, 16'hFFFF);
    end_writes();
    run_drive(60, 4);
    drain();
  endtask

  task automatic test_long_pulse();
    apply_config(16'd2, 16'd65534, 16'd1023);
    send_beat(beat_of(16'h0027, TgtEnabled, 1'b1));
    run_drive(1040, 2);
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_model.max_init_retries   = MaxRetriesRst;
    cfg_model.stuck_threshold    = StuckThrRst;
    cfg_model.reset_pulse_length = PulseLenRst;
    fr_pending = 1'b0;
    fr_count   = '0;
    stuck_cnt  = '0;
    retry_cnt  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_state_decode();
    test_fault_reset();
    set_pace(9, 46);
    test_random_drive(16'(MaxRetriesRst), StuckThrRst, 16'(PulseLenRst), 70);
    test_random_drive(16'd0, 16'd0, 16'd0, 70);
    set_pace(46, 9);
    test_random_drive(16'd255, 16'd3, 16'd1, 70);
    test_backpressure();
    set_pace(46, 9);
    test_register_masking();
    set_pace(0, 0);
    test_long_pulse();

    $display("Checked %0d of %0d beats over %0d register settings", beats_checked,
             beats_sent, settings_used);
    $display("Covered all decoded states, targets, fault reset pulses and a %0d-cycle stall",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dscg_pkg.sv
hw/rtl/dscg_stream_if.sv
hw/rtl/dscg_decode.sv
hw/rtl/dscg_ctrl.sv
hw/rtl/drive_state_controlword_generator_core.sv
hw/rtl/dscg_checker.sv
test/tb.sv
